@@ rtl/fixed_width_histogram_core_assert.svh @@
// Assertion macros for the fixed-width histogram core.
// Included by the RTL files that check their own logic; depends on nothing.
`ifndef FIXED_WIDTH_HISTOGRAM_CORE_ASSERT_SVH
`define FIXED_WIDTH_HISTOGRAM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define FWH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define FWH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fwh_pkg.sv @@
// Shared types and constants of the fixed-width histogram core.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fwh_pkg;

   // Sizes
   localparam int NUM_BINS        = 256;
   localparam int BIN_IDX_W       = $clog2(NUM_BINS);
   localparam int HW_W            = BIN_IDX_W + 1;
   localparam int DATA_W          = 32;
   localparam int START_W         = 40;
   localparam int DIV_CNT_W       = $clog2(DATA_W);
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam logic [DATA_W-1:0] BIN_WIDTH_RESET = 32'h0001_0000;

   // Item operation
   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // Result status
   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_RANGE = 1'b1
   } status_type;

   // Register index (byte address bits above the word offset)
   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_BIN_WIDTH = '0
   } reg_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

@@ rtl/fwh_if.sv @@
// Valid/ready channel interfaces for the histogram request and result items.
// Depends on fwh_pkg for field types and widths.
`timescale 1ns / 1ps
`default_nettype none

interface fwh_req_if import fwh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   op_type               op;
   logic [DATA_W-1:0]    sample;
   logic [BIN_IDX_W-1:0] bin_index;

   modport source (output valid, op, sample, bin_index, input ready);
   modport sink   (input valid, op, sample, bin_index, output ready);
endinterface

interface fwh_rsp_if import fwh_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  bin_count;
   logic [HW_W-1:0]    bins_used;
   logic [START_W-1:0] bin_start;
   status_type         status;

   modport source (output valid, bin_count, bins_used, bin_start, status, input ready);
   modport sink   (input valid, bin_count, bins_used, bin_start, status, output ready);
endinterface

`default_nettype wire

@@ rtl/fwh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module fwh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/fixed_width_histogram_core.sv @@
// Histogram of unsigned Q16.16 samples over 256 bins of equal, programmable
// width. An add item passes from acceptance to a result on the rsp channel
// through the restoring divider that finds the bin (one quotient bit a cycle),
// then a bin-store read, an update and the result state; a read item skips
// the divider. The block takes one item at a time: a new item is accepted
// only after the result of the last one has been taken.
// The bin store needs no clearing pass: per-bin valid bits, cleared by reset,
// make untouched bins read as zero. Write bin_width only while the block is idle.
// Depends on fwh_pkg, fwh_if, fwh_ram and fixed_width_histogram_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_width_histogram_core_assert.svh"

module fixed_width_histogram_core import fwh_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   fwh_req_if.sink                    req_if,
   fwh_rsp_if.source                  rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   state_type            state_ff, state_in;
   logic [DATA_W-1:0]    bin_width_ff;
   logic [HW_W-1:0]      hw_ff, hw_in;
   logic [NUM_BINS-1:0]  valid_ff;
   op_type               op_ff;
   logic [BIN_IDX_W-1:0] bin_ff;
   logic                 range_err_ff;
   logic [DATA_W-1:0]    rem_ff, dividend_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DATA_W-1:0]    res_count_ff;
   logic [HW_W-1:0]      res_used_ff;
   logic [START_W-1:0]   res_start_ff;
   status_type           res_status_ff;

   logic                 req_take;
   logic                 div_run;
   logic                 lookup_en;
   logic                 update_en;
   logic                 csr_wr;
   reg_type              csr_reg;
   logic [DATA_W:0]      rem_shift;
   logic [DATA_W:0]      rem_diff;
   logic                 quo_bit;
   logic [DATA_W-1:0]    quo_next;
   logic [DATA_W-1:0]    ram_rdata;
   logic [DATA_W-1:0]    count_old;
   logic [DATA_W-1:0]    count_inc;
   logic                 upd_err;
   logic                 wr_en;
   logic [HW_W-1:0]      bin_plus;
   logic [START_W-1:0]   start_prod;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_reg = reg_type'(paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      unique case (csr_reg)
         REG_BIN_WIDTH: prdata = bin_width_ff;
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= BIN_WIDTH_RESET;
      end else if (csr_wr && csr_reg == REG_BIN_WIDTH) begin
         bin_width_ff <= pwdata;
      end
   end

   // ---------------- sequencer ----------------
   assign req_take = req_if.valid & req_if.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_if.op == OP_ADD) ? ST_DIVIDE : ST_LOOKUP;
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP:  state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      div_run      = 1'b0;
      lookup_en    = 1'b0;
      update_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_if.ready = 1'b1;
         ST_DIVIDE:  div_run      = 1'b1;
         ST_LOOKUP:  lookup_en    = 1'b1;
         ST_UPDATE:  update_en    = 1'b1;
         ST_RESPOND: rsp_if.valid = 1'b1;
         default:    req_if.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- restoring divider: one quotient bit a cycle ----------------
   // A zero divisor yields all ones, which lands out of range.
   assign rem_shift = {rem_ff, dividend_ff[DATA_W-1]};
   assign rem_diff  = rem_shift - {1'b0, bin_width_ff};
   assign quo_bit   = (rem_shift >= {1'b0, bin_width_ff});
   assign quo_next  = {dividend_ff[DATA_W-2:0], quo_bit};

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff        <= req_if.op;
         bin_ff       <= req_if.bin_index;
         dividend_ff  <= req_if.sample;
         rem_ff       <= '0;
         cnt_ff       <= '1;
         range_err_ff <= 1'b0;
      end else if (div_run) begin
         rem_ff      <= quo_bit ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
         dividend_ff <= quo_next;
         cnt_ff      <= cnt_ff - 1'b1;
         // Last bit: latch the bin and flag quotients past the last bin
         if (cnt_ff == '0) begin
            bin_ff       <= quo_next[BIN_IDX_W-1:0];
            range_err_ff <= (quo_next >= DATA_W'(NUM_BINS));
         end
      end
   end

   // ---------------- bin store ----------------
   fwh_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_BINS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bin_ff),
      .wr_data (count_inc),
      .rd_en   (lookup_en),
      .rd_addr (bin_ff),
      .rd_data (ram_rdata)
   );

   // Update: untouched bins read as zero, counts saturate
   assign count_old = valid_ff[bin_ff] ? ram_rdata : '0;
   assign count_inc = (count_old == '1) ? count_old : count_old + 1'b1;
   assign bin_plus  = {1'b0, bin_ff} + 1'b1;
   assign upd_err   = (op_ff == OP_ADD) ? range_err_ff : ({1'b0, bin_ff} >= hw_ff);
   assign wr_en     = update_en & (op_ff == OP_ADD) & ~range_err_ff;
   assign hw_in     = (wr_en && bin_plus > hw_ff) ? bin_plus : hw_ff;
   assign start_prod = {{(START_W-BIN_IDX_W){1'b0}}, bin_ff}
                     * {{(START_W-DATA_W){1'b0}}, bin_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hw_ff    <= '0;
      end else if (update_en) begin
         hw_ff <= hw_in;
         if (wr_en) begin
            valid_ff[bin_ff] <= 1'b1;
         end
      end
   end

   // Hold the result until the rsp side takes it
   always_ff @(posedge clock) begin
      if (update_en) begin
         res_used_ff   <= hw_in;
         res_status_ff <= upd_err ? STATUS_RANGE : STATUS_OK;
         res_count_ff  <= upd_err ? '0 : ((op_ff == OP_ADD) ? count_inc : count_old);
         res_start_ff  <= upd_err ? '0 : start_prod;
      end
   end

   assign rsp_if.bin_count = res_count_ff;
   assign rsp_if.bins_used = res_used_ff;
   assign rsp_if.bin_start = res_start_ff;
   assign rsp_if.status    = res_status_ff;

   // ---------------- checks ----------------
   `FWH_ASSERT_NOW(a_one_item_at_a_time, clock, reset,
      req_if.ready, !rsp_if.valid, "request taken while a result is pending")
   `FWH_ASSERT_NOW(a_ok_has_bins, clock, reset,
      rsp_if.valid && rsp_if.status == STATUS_OK, rsp_if.bins_used != '0,
      "good result with no bins in use")
   `FWH_ASSERT_NEXT(a_write_marks_valid, clock, reset,
      wr_en, valid_ff[$past(bin_ff)], "written bin not marked valid")
   `FWH_ASSERT_NOW(a_high_water_rises, clock, reset,
      !$past(reset), hw_ff >= $past(hw_ff), "high-water mark went down")

endmodule

`default_nettype wire
